// File: hdl/fsme_pkg.sv
// Shared types and constants for the stream tap-multiply engine.
package fsme_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int STREAMS       = 4;
    localparam int SID_W         = 2;
    localparam int WADDR_W       = 30;

    localparam logic [31:0] DEFAULT_TAPS   = 32'd16;
    localparam logic [31:0] DEFAULT_STRIDE = 32'd4;

    typedef enum logic [1:0] {
        CMD_DESC    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_MEMWR   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // Descriptor field selects; the codes not listed are accepted and ignored.
    localparam logic [2:0] FLD_SHAPE  = 3'd0;
    localparam logic [2:0] FLD_LIMIT  = 3'd1;
    localparam logic [2:0] FLD_OFFSET = 3'd3;
    localparam logic [2:0] FLD_STRIDE = 3'd4;
    localparam logic [2:0] FLD_BASE   = 3'd7;

    typedef enum logic [1:0] {
        MUL_CADDR,
        MUL_SADDR,
        MUL_PROD
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DESC,
        ST_CLEAR,
        ST_MW_MOD,
        ST_MW_WAIT,
        ST_PREP_C,
        ST_PREP_S,
        ST_C_MUL,
        ST_C_ADD,
        ST_C_WAIT,
        ST_C_CAP,
        ST_S_MUL,
        ST_S_ADD,
        ST_S_WAIT,
        ST_S_CAP,
        ST_P_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     latch_in;
        logic     use_sample;
        logic     prep_c;
        logic     prep_s;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mod_start;
        logic     mod_addr;
        logic     ram_rd;
        logic     ram_wr;
        logic     cap_coeff;
        logic     cap_sample;
        logic     desc_wr;
        logic     clear;
        logic     emit;
    } dp_ctrl_t;

endpackage

// File: hdl/fsme_ram.sv
// Generic single-port RAM with registered read data.
module fsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/fsme_wmod.sv
// Word address reduction modulo memory depth: bit select or reciprocal multiplication.
module fsme_wmod
    import fsme_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [WADDR_W-1:0]           operand,
    output logic                         done,
    output logic [$clog2(MEM_WORDS)-1:0] index
);

    localparam int AW      = $clog2(MEM_WORDS);
    localparam int SHIFT   = WADDR_W + AW;
    localparam int QW      = WADDR_W - AW + 1;
    localparam bit IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [WADDR_W:0]   RECIP = RECIP_FULL[WADDR_W:0];
    localparam logic [WADDR_W-1:0] MOD_M = WADDR_W'(MEM_WORDS);
    localparam logic [1:0]         STEPS = 2'd2;

    logic [AW-1:0]      rem_reg;
    logic [WADDR_W-1:0] div_reg;
    logic [QW-1:0]      quot_reg;
    logic [1:0]         cnt_reg;
    logic               done_reg;
    logic [2*WADDR_W:0] recip_prod;
    logic [WADDR_W-1:0] back_prod;
    logic [WADDR_W-1:0] rem_full;

    // The rounded-up reciprocal gives the exact quotient for every 30-bit operand;
    // the remainder is then the operand minus quotient times depth.
    assign recip_prod = div_reg * RECIP;
    assign back_prod  = WADDR_W'(quot_reg) * MOD_M;
    assign rem_full   = div_reg - back_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= IS_POW2 ? '0 : STEPS;
            done_reg <= IS_POW2;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 2'd1;
            done_reg <= (cnt_reg == 2'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= operand;
            rem_reg <= IS_POW2 ? operand[AW-1:0] : '0;
        end
        else if (cnt_reg == 2'd2)
        begin
            quot_reg <= recip_prod[2*WADDR_W:SHIFT];
        end
        else if (cnt_reg == 2'd1)
        begin
            rem_reg <= rem_full[AW-1:0];
        end
    end

    assign done  = done_reg;
    assign index = rem_reg;

endmodule

// File: hdl/fsme_dp.sv
// Datapath: descriptors, counters, shared multiplier, memory and result registers.
module fsme_dp
    import fsme_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctl,
    output logic               mod_done,
    input  logic [1:0]         cmd,
    input  logic [SID_W-1:0]   stream_id,
    input  logic [SID_W-1:0]   coeff_stream,
    input  logic [2:0]         field_sel,
    input  logic [31:0]        value,
    input  logic [9:0]         mem_index,
    input  logic [4:0]         dest_reg,
    output logic               done,
    output logic               result_valid,
    output logic [4:0]         result_reg,
    output logic signed [31:0] product
);

    localparam int AW = $clog2(MEM_WORDS);

    cmd_t             cmd_reg;
    logic [SID_W-1:0] sid_reg, cid_reg;
    logic [2:0]       sel_reg;
    logic [31:0]      value_reg;
    logic [9:0]       midx_reg;
    logic [4:0]       dreg_reg;

    logic [31:0] base_reg   [STREAMS];
    logic [31:0] stride_reg [STREAMS];
    logic [31:0] limit_reg  [STREAMS];
    logic [15:0] length_reg [STREAMS];
    logic [31:0] offset_reg [STREAMS];
    logic [31:0] tap_reg, win_reg;

    logic [31:0] order_reg, cidx_reg, sidx_reg, cstr_reg, sstr_reg;
    logic [31:0] mul_reg, coeff_reg, sample_reg;

    logic        done_reg, valid_reg;
    logic [4:0]  rreg_reg;
    logic [31:0] prod_reg;

    logic [SID_W-1:0]   rd_id;
    logic [31:0]        d_base, d_stride, d_limit, d_offset, d_str_eff;
    logic [15:0]        d_length;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_full;
    logic [31:0]        addr_sum;
    logic [WADDR_W-1:0] mod_operand;
    logic [AW-1:0]      mem_addr;
    logic [31:0]        ram_rdata;
    logic [31:0]        tap_inc;

    // One descriptor is looked at per cycle: coefficient or sample stream.
    always_comb
    begin
        rd_id     = ctl.use_sample ? sid_reg : cid_reg;
        d_base    = base_reg[rd_id];
        d_stride  = stride_reg[rd_id];
        d_limit   = limit_reg[rd_id];
        d_length  = length_reg[rd_id];
        d_offset  = offset_reg[rd_id];
        d_str_eff = (d_stride != '0) ? d_stride : DEFAULT_STRIDE;
    end

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_CADDR:
            begin
                mul_a = cidx_reg;
                mul_b = cstr_reg;
            end
            MUL_SADDR:
            begin
                mul_a = sidx_reg;
                mul_b = sstr_reg;
            end
            default:
            begin
                mul_a = coeff_reg;
                mul_b = sample_reg;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    assign addr_sum    = d_base + mul_reg;
    assign mod_operand = ctl.mod_addr ? addr_sum[31:2] : WADDR_W'(midx_reg);
    assign tap_inc     = tap_reg + 32'd1;

    fsme_wmod #(
        .MEM_WORDS(MEM_WORDS)
    ) u_wmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.mod_start),
        .operand(mod_operand),
        .done   (mod_done),
        .index  (mem_addr)
    );

    fsme_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (ctl.ram_wr),
        .re   (ctl.ram_rd),
        .addr (mem_addr),
        .wdata(value_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg   <= cmd_t'(cmd);
            sid_reg   <= stream_id;
            cid_reg   <= coeff_stream;
            sel_reg   <= field_sel;
            value_reg <= value;
            midx_reg  <= mem_index;
            dreg_reg  <= dest_reg;
        end
        if (ctl.prep_c)
        begin
            if (d_limit != '0)
            begin
                order_reg <= d_limit;
            end
            else if (d_length != '0)
            begin
                order_reg <= {16'd0, d_length};
            end
            else
            begin
                order_reg <= DEFAULT_TAPS;
            end
            cidx_reg <= tap_reg + d_offset;
            cstr_reg <= d_str_eff;
        end
        if (ctl.prep_s)
        begin
            sidx_reg <= win_reg + tap_reg + ((d_offset != '0) ? d_offset - 32'd1 : 32'd0);
            sstr_reg <= d_str_eff;
        end
        if (ctl.mul_en)
        begin
            mul_reg <= mul_full[31:0];
        end
        if (ctl.cap_coeff)
        begin
            coeff_reg <= ram_rdata;
        end
        if (ctl.cap_sample)
        begin
            sample_reg <= ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STREAMS; i++)
            begin
                base_reg[i]   <= '0;
                stride_reg[i] <= '0;
                limit_reg[i]  <= '0;
                length_reg[i] <= '0;
                offset_reg[i] <= '0;
            end
            tap_reg <= '0;
            win_reg <= '0;
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < STREAMS; i++)
            begin
                base_reg[i]   <= '0;
                stride_reg[i] <= '0;
                limit_reg[i]  <= '0;
                length_reg[i] <= '0;
                offset_reg[i] <= '0;
            end
            tap_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            if (ctl.desc_wr)
            begin
                unique case (sel_reg)
                    FLD_SHAPE:  length_reg[sid_reg] <= value_reg[31:16];
                    FLD_LIMIT:  limit_reg[sid_reg]  <= value_reg;
                    FLD_OFFSET: offset_reg[sid_reg] <= value_reg;
                    FLD_STRIDE: stride_reg[sid_reg] <= value_reg;
                    FLD_BASE:   base_reg[sid_reg]   <= value_reg;
                    default:    ;
                endcase
            end
            if (ctl.emit && cmd_reg == CMD_STEP)
            begin
                if (tap_inc >= order_reg)
                begin
                    tap_reg <= '0;
                    win_reg <= win_reg + 32'd1;
                end
                else
                begin
                    tap_reg <= tap_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            rreg_reg  <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            done_reg <= ctl.emit;
            if (ctl.emit)
            begin
                valid_reg <= (cmd_reg == CMD_STEP);
                rreg_reg  <= (cmd_reg == CMD_STEP) ? dreg_reg : 5'd0;
                prod_reg  <= (cmd_reg == CMD_STEP) ? mul_reg : 32'd0;
            end
        end
    end

    assign done         = done_reg;
    assign result_valid = valid_reg;
    assign result_reg   = rreg_reg;
    assign product      = prod_reg;

endmodule

// File: hdl/fsme_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module fsme_ctrl
    import fsme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] cmd,
    input  logic       mod_done,
    output logic       busy,
    output dp_ctrl_t   ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.mul_sel = MUL_CADDR;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    unique case (cmd_t'(cmd))
                        CMD_DESC:    state_next = ST_DESC;
                        CMD_STEP:    state_next = ST_PREP_C;
                        CMD_MEMWR:   state_next = ST_MW_MOD;
                        CMD_RESTART: state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_DESC:
            begin
                ctl.desc_wr = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_CLEAR:
            begin
                ctl.clear  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_MW_MOD:
            begin
                ctl.mod_start = 1'b1;
                state_next    = ST_MW_WAIT;
            end
            ST_MW_WAIT:
            begin
                if (mod_done)
                begin
                    ctl.ram_wr = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_PREP_C:
            begin
                ctl.prep_c = 1'b1;
                state_next = ST_PREP_S;
            end
            ST_PREP_S:
            begin
                ctl.use_sample = 1'b1;
                ctl.prep_s     = 1'b1;
                state_next     = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_CADDR;
                state_next  = ST_C_ADD;
            end
            ST_C_ADD:
            begin
                ctl.mod_start = 1'b1;
                ctl.mod_addr  = 1'b1;
                state_next    = ST_C_WAIT;
            end
            ST_C_WAIT:
            begin
                if (mod_done)
                begin
                    ctl.ram_rd = 1'b1;
                    state_next = ST_C_CAP;
                end
            end
            ST_C_CAP:
            begin
                ctl.cap_coeff = 1'b1;
                state_next    = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_SADDR;
                state_next  = ST_S_ADD;
            end
            ST_S_ADD:
            begin
                ctl.use_sample = 1'b1;
                ctl.mod_start  = 1'b1;
                ctl.mod_addr   = 1'b1;
                state_next     = ST_S_WAIT;
            end
            ST_S_WAIT:
            begin
                if (mod_done)
                begin
                    ctl.ram_rd = 1'b1;
                    state_next = ST_S_CAP;
                end
            end
            ST_S_CAP:
            begin
                ctl.cap_sample = 1'b1;
                state_next     = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_PROD;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctl.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/fir_stream_tap_multiply_engine.sv
// Top level of the stream tap-multiply engine: controller plus datapath.
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------------
//  request   start in, busy out   cmd, stream_id, coeff_stream, field_sel, value,
//                                 mem_index, dest_reg
//  result    done out (strobe)    result_valid, result_reg, product
//
// Every request gives one result, strobed on done for a single cycle.
// Descriptor writes and restarts use no memory. A memory write waits once, and a
// tap step twice, on the word-index reduction; it keeps the low address bits when
// MEM_WORDS is a power of two and uses reciprocal multiplication otherwise.
// One shared multiplier and the single memory port set the step sequence.
// Reset clears descriptors, counters and the controller; memory is not cleared.
// The result side cannot stall; done is registered, so a new request is taken
// in the same cycle that the previous result is shown.
module fir_stream_tap_multiply_engine
    import fsme_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [1:0]         stream_id,
    input  logic [1:0]         coeff_stream,
    input  logic [2:0]         field_sel,
    input  logic [31:0]        value,
    input  logic [9:0]         mem_index,
    input  logic [4:0]         dest_reg,
    output logic               done,
    output logic               result_valid,
    output logic [4:0]         result_reg,
    output logic signed [31:0] product
);

    dp_ctrl_t ctl;
    logic     mod_done;

    fsme_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .mod_done(mod_done),
        .busy    (busy),
        .ctl     (ctl)
    );

    fsme_dp #(
        .MEM_WORDS(MEM_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .mod_done    (mod_done),
        .cmd         (cmd),
        .stream_id   (stream_id),
        .coeff_stream(coeff_stream),
        .field_sel   (field_sel),
        .value       (value),
        .mem_index   (mem_index),
        .dest_reg    (dest_reg),
        .done        (done),
        .result_valid(result_valid),
        .result_reg  (result_reg),
        .product     (product)
    );

endmodule
